### sv/b64se_pkg.sv
`timescale 1ns / 1ps

package b64se_pkg;

    localparam int BYTE_W = 8;
    localparam int CODE_W = 6;
    localparam int CHAR_W = 7;
    localparam int TDATA_W = 8;
    localparam int QUEUE_DEPTH = 2;

    // position within the current 3-byte group
    typedef enum logic [1:0] {
        PH_0 = 2'd0,
        PH_1 = 2'd1,
        PH_2 = 2'd2
    } phase_t;

    // one byte worth of work for the back end: one or two 6-bit codes
    typedef struct packed {
        logic [CODE_W-1:0] code0;
        logic [CODE_W-1:0] code1;
        logic              two;
        logic              last;
    } grp_t;

    function automatic logic [CHAR_W-1:0] code_to_char(input logic [CODE_W-1:0] v);
        logic [CHAR_W-1:0] w;
        logic [CHAR_W-1:0] c;
        begin
            w = {1'b0, v};
            if (v < 6'd26)
            begin
                c = w + 7'd65;
            end
            else if (v < 6'd52)
            begin
                c = w + 7'd71;
            end
            else if (v < 6'd62)
            begin
                c = w - 7'd4;
            end
            else if (v == 6'd62)
            begin
                c = 7'd43;
            end
            else
            begin
                c = 7'd47;
            end
            return c;
        end
    endfunction

endpackage

### sv/b64se_front.sv
`timescale 1ns / 1ps

module b64se_front
    import b64se_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [BYTE_W-1:0] in_byte,
    input  logic              in_last,
    input  logic              push_ready,
    output logic              in_ready,
    output logic              push,
    output grp_t              push_data
);

    phase_t            phase_reg;
    phase_t            phase_next;
    logic [CODE_W-1:0] pend_reg;
    logic [CODE_W-1:0] pend_next;
    logic              take;

    assign in_ready = push_ready;
    assign take     = in_valid && push_ready;
    assign push     = take;

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        pend_next  = pend_reg;
        if (take)
        begin
            case (phase_reg)
                PH_1:
                begin
                    phase_next = PH_2;
                    pend_next  = {in_byte[3:0], 2'b00};
                end
                PH_2:
                begin
                    phase_next = PH_0;
                    pend_next  = '0;
                end
                default:
                begin
                    phase_next = PH_1;
                    pend_next  = {in_byte[1:0], 4'b0000};
                end
            endcase
            if (in_last)
            begin
                phase_next = PH_0;
                pend_next  = '0;
            end
        end
    end

    // outputs: codes for the queue
    always_comb
    begin
        push_data.last = in_last;
        case (phase_reg)
            PH_1:
            begin
                push_data.code0 = pend_reg | {2'b00, in_byte[7:4]};
                push_data.code1 = {in_byte[3:0], 2'b00};
                push_data.two   = in_last;
            end
            PH_2:
            begin
                push_data.code0 = pend_reg | {4'b0000, in_byte[7:6]};
                push_data.code1 = in_byte[5:0];
                push_data.two   = 1'b1;
            end
            default:
            begin
                push_data.code0 = in_byte[7:2];
                push_data.code1 = {in_byte[1:0], 4'b0000};
                push_data.two   = in_last;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_0;
            pend_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            pend_reg  <= pend_next;
        end
    end

endmodule

### sv/b64se_queue.sv
`timescale 1ns / 1ps

module b64se_queue
    import b64se_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  grp_t push_data,
    output logic push_ready,
    input  logic pop,
    output logic pop_valid,
    output grp_t pop_data
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    grp_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### sv/b64se_back.sv
`timescale 1ns / 1ps

module b64se_back
    import b64se_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pop_valid,
    input  grp_t              pop_data,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [CHAR_W-1:0] out_char,
    output logic              out_last
);

    logic              sub_reg;
    logic              sub_next;
    logic              valid_reg;
    logic              valid_next;
    logic [CHAR_W-1:0] char_reg;
    logic [CHAR_W-1:0] char_next;
    logic              last_reg;
    logic              last_next;
    logic              load;
    logic [CODE_W-1:0] code_sel;

    assign load     = !valid_reg || out_ready;
    assign code_sel = sub_reg ? pop_data.code1 : pop_data.code0;

    always_comb
    begin
        sub_next   = sub_reg;
        valid_next = valid_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        pop        = 1'b0;
        if (load)
        begin
            valid_next = pop_valid;
            if (pop_valid)
            begin
                char_next = code_to_char(code_sel);
                if (sub_reg)
                begin
                    last_next = pop_data.last;
                    sub_next  = 1'b0;
                    pop       = 1'b1;
                end
                else
                begin
                    // first char of a two-char entry is never the final one
                    last_next = pop_data.last && !pop_data.two;
                    sub_next  = pop_data.two;
                    pop       = !pop_data.two;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            sub_reg   <= sub_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign out_valid = valid_reg;
    assign out_char  = char_reg;
    assign out_last  = last_reg;

endmodule

### sv/base64_stream_encoder_unit.sv
`timescale 1ns / 1ps
// path: the first character of an accepted byte goes through the queue and then the
//   output register before it is on m_tdata; m_tready low holds it there
// throughput: one character per cycle from the output register while m_tready is high
//   and the queue is not empty; a two-char byte is popped with its second char
// reset: asynchronous active low, clears group position, leftover bits and queue

module base64_stream_encoder_unit
    import b64se_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,   // [7:0] in_byte
    input  logic               s_tlast,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // [6:0] out_char, [7] zero
    output logic               m_tlast
);

    logic              push;
    logic              push_ready;
    grp_t              push_data;
    logic              pop;
    logic              pop_valid;
    grp_t              pop_data;
    logic [CHAR_W-1:0] out_char;

    // a two-entry queue between the byte classifier and the character serializer
    b64se_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_byte    (s_tdata[BYTE_W-1:0]),
        .in_last    (s_tlast),
        .push_ready (push_ready),
        .in_ready   (s_tready),
        .push       (push),
        .push_data  (push_data)
    );

    b64se_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_data   (pop_data)
    );

    b64se_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_data  (pop_data),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_char  (out_char),
        .out_last  (m_tlast)
    );

    assign m_tdata = {{(TDATA_W - CHAR_W){1'b0}}, out_char};

endmodule
